### sv/assert_macros.svh
// Assertion macros shared by the checker files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check cons in the same cycle as ante
`define CHK_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// check cons in the cycle after ante
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### sv/tle_pkg.sv
// Types, register map and command codes of the tricorn escape-time engine.
// No dependencies; used by every module of the block.
`default_nettype none

package tle_pkg;

	localparam int FRAC_BITS_DEF = 24;
	localparam int CFG_AW        = 5;

	localparam logic signed [31:0] P_RE_RST     = 32'sd8388608;
	localparam logic signed [31:0] P_IM_RST     = 32'sd0;
	localparam logic signed [31:0] PHASE_RST    = 32'sd0;
	localparam logic [30:0]        EPS_RST      = 31'd83886;
	localparam logic [15:0]        MAX_ITER_RST = 16'd10000;

	typedef enum logic [2:0] {
		REG_P_RE     = 3'd0,
		REG_P_IM     = 3'd1,
		REG_PHASE    = 3'd2,
		REG_EPS      = 3'd3,
		REG_MAX_ITER = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic              action;
		logic signed [31:0] z_re;
		logic signed [31:0] z_im;
	} item_t;

	typedef struct packed {
		logic              escaped;
		logic [16:0]       count;
		logic signed [31:0] z_re_out;
		logic signed [31:0] z_im_out;
	} result_t;

	typedef struct packed {
		logic signed [31:0] p_re;
		logic signed [31:0] p_im;
		logic signed [31:0] phase;
		logic [30:0]        eps;
		logic [15:0]        max_iter;
	} cfg_t;

	typedef enum logic [5:0] {
		OP_NOP,
		OP_LOAD,
		OP_SU_A, OP_SU_B, OP_SU_C, OP_SU_D, OP_SU_E,
		OP_IT_A, OP_IT_B, OP_IT_C, OP_IT_D, OP_IT_E, OP_IT_F, OP_IT_G,
		OP_IT_H, OP_IT_I, OP_IT_J, OP_IT_K, OP_IT_L, OP_IT_M, OP_IT_N,
		OP_RC_A, OP_RC_B, OP_RC_C, OP_RC_SRE, OP_RC_SIM,
		OP_LV_A, OP_LV_B, OP_LV_C, OP_LV_D, OP_LV_E, OP_LV_F,
		OP_FIN,
		OP_COMMIT,
		OP_OUT
	} op_t;

	typedef struct packed {
		op_t  op;
		logic div_start;
		logic div_im;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic esc_hit;
		logic limit;
		logic cap;
		logic step;
	} stat_t;

endpackage

`default_nettype wire

### sv/tle_dp.sv
// Datapath: shared 32x32 multiplier, accumulator, saturation and a
// bit-serial divider for the reciprocals. Depends on tle_pkg.
`default_nettype none

module tle_dp
	import tle_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cmd_t    cmd,
	input  item_t   item,
	input  cfg_t    cfg,
	output stat_t   stat,
	output result_t result
);

	localparam int ACC_W     = ((64 - FRAC_BITS > 32) ? 64 - FRAC_BITS : 32) + 6;
	localparam int DIV_STEPS = 32 + 2 * FRAC_BITS;
	localparam int KW        = $clog2(DIV_STEPS);
	localparam logic [63:0] ESC_LIM = 64'd10 << FRAC_BITS;
	localparam logic signed [ACC_W-1:0] S_MAX = ACC_W'(64'sh7FFFFFFF);
	localparam logic signed [ACC_W-1:0] S_MIN = ~S_MAX;

	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
		if (v > S_MAX)
			return 32'sh7FFFFFFF;
		else if (v < S_MIN)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

	function automatic logic signed [ACC_W-1:0] ext(input logic signed [31:0] v);
		return ACC_W'(v);
	endfunction

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		logic [31:0] u;
		u = v;
		return v[31] ? (~u + 32'd1) : u;
	endfunction

	logic signed [31:0] pre, pim, phs, epsx;
	logic signed [31:0] ma, mb;
	logic signed [63:0] prod_q;
	logic signed [ACC_W-1:0] fm;

	logic signed [31:0] z_re_q, z_im_q, n_re_q, n_im_q, e_re_q, e_im_q;
	logic signed [31:0] d_re_q, d_im_q, vr_q, x_re_q, x_im_q;
	logic signed [31:0] y_re_q, y_im_q, w_re_q, w_im_q;
	logic signed [31:0] c_re_q, c_im_q, a_re_q, a_im_q;
	logic signed [ACC_W-1:0] sqr_q, sqi_q, acc_q;
	logic [63:0] t0_q, norm_q;
	logic        cap_q, step_q;
	logic [15:0] i_q;
	result_t     res_q;

	logic [31:0]   dvd_q, quo_q, quo_nx;
	logic [64:0]   rem_q, rem_sh, rem_nx;
	logic [32:0]   quo_sh;
	logic [KW-1:0] k_q;
	logic          busy_q, div_bit, q_bit;

	logic signed [ACC_W-1:0] qa, adj;
	logic [31:0] ip;
	logic        limit, escaped;

	assign pre  = cfg.p_re;
	assign pim  = cfg.p_im;
	assign phs  = cfg.phase;
	assign epsx = {1'b0, cfg.eps};

	assign fm = ACC_W'(prod_q >>> FRAC_BITS);
	assign qa = ACC_W'({1'b0, quo_q});
	assign ip = (mag32(y_re_q) >> FRAC_BITS) << FRAC_BITS;
	assign adj = ACC_W'({1'b0, ip, 1'b0});
	assign limit = (i_q >= cfg.max_iter);
	assign escaped = !step_q && !limit;

	always_comb begin
		ma = '0;
		mb = '0;
		unique case (cmd.op)
			OP_SU_A: begin ma = pre;    mb = pre;    end
			OP_SU_B: begin ma = pim;    mb = pim;    end
			OP_SU_C: begin ma = pre;    mb = pim;    end
			OP_IT_A: begin ma = z_re_q; mb = z_re_q; end
			OP_IT_B: begin ma = z_im_q; mb = z_im_q; end
			OP_IT_C: begin ma = z_re_q; mb = z_im_q; end
			OP_IT_E: begin ma = a_re_q; mb = e_re_q; end
			OP_IT_F: begin ma = a_im_q; mb = e_im_q; end
			OP_IT_G: begin ma = a_re_q; mb = e_im_q; end
			OP_IT_H: begin ma = a_im_q; mb = e_re_q; end
			OP_IT_J: begin ma = vr_q;   mb = vr_q;   end
			OP_IT_K: begin ma = d_im_q; mb = d_im_q; end
			OP_IT_L: begin ma = epsx;   mb = epsx;   end
			OP_RC_A: begin ma = x_re_q; mb = x_re_q; end
			OP_RC_B: begin ma = x_im_q; mb = x_im_q; end
			OP_LV_B: begin ma = a_re_q; mb = w_re_q; end
			OP_LV_C: begin ma = a_im_q; mb = w_im_q; end
			OP_LV_D: begin ma = a_re_q; mb = w_im_q; end
			OP_LV_E: begin ma = a_im_q; mb = w_re_q; end
			default: begin ma = '0;     mb = '0;     end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= ma * mb;
		unique case (cmd.op)
			OP_LOAD: begin
				z_re_q <= item.z_re;
				z_im_q <= item.z_im;
				step_q <= item.action;
				i_q    <= '0;
			end
			OP_SU_B: sqr_q <= fm;
			OP_SU_C: sqr_q <= sqr_q - fm;
			OP_SU_D: sqi_q <= fm <<< 1;
			OP_SU_E: begin
				c_re_q <= sat32(ext(pre) - sqr_q);
				c_im_q <= sat32(ext(pim) + sqi_q);
				a_re_q <= sat32((sqr_q <<< 2) + (ext(pre) <<< 1));
				a_im_q <= sat32((sqi_q <<< 2) - (ext(pim) <<< 1));
			end
			OP_IT_B: begin
				t0_q  <= prod_q;
				acc_q <= fm + ext(c_re_q);
			end
			OP_IT_C: begin
				t0_q   <= t0_q + prod_q;
				n_re_q <= sat32(acc_q - fm);
			end
			OP_IT_D: begin
				n_im_q <= sat32(ext(c_im_q) - (fm <<< 1));
				e_re_q <= sat32(ext(n_re_q) - ext(pre));
			end
			OP_IT_E: e_im_q <= sat32(ext(n_im_q) - ext(pim));
			OP_IT_F: acc_q <= fm;
			OP_IT_G: d_re_q <= sat32(acc_q - fm);
			OP_IT_H: acc_q <= fm;
			OP_IT_I: begin
				d_im_q <= sat32(acc_q + fm);
				vr_q   <= sat32(ext(d_re_q) + ext(epsx));
			end
			OP_IT_K: t0_q <= prod_q;
			OP_IT_L: t0_q <= t0_q + prod_q;
			OP_IT_M: cap_q <= (t0_q < prod_q);
			OP_IT_N: begin
				x_re_q <= d_re_q;
				x_im_q <= d_im_q;
			end
			OP_RC_B: t0_q <= prod_q;
			OP_RC_C: norm_q <= t0_q + prod_q;
			OP_RC_SRE: y_re_q <= (norm_q == '0) ? '0 : sat32((x_re_q > 0) ? -qa : qa);
			OP_RC_SIM: y_im_q <= (norm_q == '0) ? '0 : sat32((x_im_q < 0) ? -qa : qa);
			OP_LV_A: begin
				w_re_q <= sat32(ext(y_re_q) - ((y_re_q < 0) ? -adj : adj) + ext(phs));
				w_im_q <= y_im_q;
			end
			OP_LV_C: acc_q <= fm;
			OP_LV_D: x_re_q <= sat32(acc_q - fm);
			OP_LV_E: acc_q <= fm;
			OP_LV_F: x_im_q <= sat32(acc_q + fm);
			OP_FIN: begin
				n_re_q <= sat32(ext(y_re_q) + ext(pre));
				n_im_q <= sat32(ext(y_im_q) + ext(pim));
			end
			OP_COMMIT: begin
				z_re_q <= n_re_q;
				z_im_q <= n_im_q;
				i_q    <= i_q + 16'd1;
			end
			OP_OUT: begin
				res_q.escaped  <= escaped;
				res_q.count    <= escaped ? {i_q, 1'b0} : 17'd0;
				res_q.z_re_out <= z_re_q;
				res_q.z_im_out <= z_im_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		div_bit = (k_q >= KW'(2 * FRAC_BITS)) ? dvd_q[31] : 1'b0;
		rem_sh  = {rem_q[63:0], div_bit};
		if (rem_sh >= {1'b0, norm_q}) begin
			rem_nx = rem_sh - {1'b0, norm_q};
			q_bit  = 1'b1;
		end else begin
			rem_nx = rem_sh;
			q_bit  = 1'b0;
		end
		quo_sh = {quo_q, q_bit};
		quo_nx = (quo_sh > 33'h080000000) ? 32'h80000000 : quo_sh[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= '0;
		end else if (cmd.div_start) begin
			busy_q <= 1'b1;
			k_q    <= KW'(DIV_STEPS - 1);
		end else if (busy_q) begin
			if (k_q == '0)
				busy_q <= 1'b0;
			else
				k_q <= k_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dvd_q <= mag32(cmd.div_im ? x_im_q : x_re_q);
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			if (k_q >= KW'(2 * FRAC_BITS))
				dvd_q <= dvd_q << 1;
			rem_q <= rem_nx;
			quo_q <= quo_nx;
		end
	end

	assign stat.div_busy = busy_q;
	assign stat.esc_hit  = ((t0_q >> FRAC_BITS) >= ESC_LIM);
	assign stat.limit    = limit;
	assign stat.cap      = cap_q;
	assign stat.step     = step_q;
	assign result        = res_q;

endmodule

`default_nettype wire

### sv/tle_ctrl.sv
// Controller: sequences setup, iteration, capture map and result beat.
// Depends on tle_pkg; drives tle_dp through cmd_t and reads stat_t.
`default_nettype none

module tle_ctrl
	import tle_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	output logic  item_ready,
	output logic  result_valid,
	input  logic  result_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	typedef enum logic [5:0] {
		ST_IDLE,
		ST_SU_A, ST_SU_B, ST_SU_C, ST_SU_D, ST_SU_E,
		ST_IT_A, ST_IT_B, ST_IT_C, ST_IT_D, ST_IT_E, ST_IT_F, ST_IT_G,
		ST_IT_H, ST_IT_I, ST_IT_J, ST_IT_K, ST_IT_L, ST_IT_M, ST_IT_N,
		ST_RC_A, ST_RC_B, ST_RC_C, ST_DRE, ST_WRE, ST_SRE, ST_DIM, ST_WIM, ST_SIM,
		ST_LV_A, ST_LV_B, ST_LV_C, ST_LV_D, ST_LV_E, ST_LV_F,
		ST_FIN, ST_COMMIT, ST_OUT
	} state_t;

	state_t state_q;
	logic   valid_q, rsel_q, slot_free;

	assign item_ready   = (state_q == ST_IDLE);
	assign result_valid = valid_q;
	assign slot_free    = !valid_q || result_ready;

	always_comb begin
		cmd.div_start = 1'b0;
		cmd.div_im    = 1'b0;
		unique case (state_q)
			ST_IDLE:   cmd.op = item_valid ? OP_LOAD : OP_NOP;
			ST_SU_A:   cmd.op = OP_SU_A;
			ST_SU_B:   cmd.op = OP_SU_B;
			ST_SU_C:   cmd.op = OP_SU_C;
			ST_SU_D:   cmd.op = OP_SU_D;
			ST_SU_E:   cmd.op = OP_SU_E;
			ST_IT_A:   cmd.op = OP_IT_A;
			ST_IT_B:   cmd.op = OP_IT_B;
			ST_IT_C:   cmd.op = OP_IT_C;
			ST_IT_D:   cmd.op = OP_IT_D;
			ST_IT_E:   cmd.op = OP_IT_E;
			ST_IT_F:   cmd.op = OP_IT_F;
			ST_IT_G:   cmd.op = OP_IT_G;
			ST_IT_H:   cmd.op = OP_IT_H;
			ST_IT_I:   cmd.op = OP_IT_I;
			ST_IT_J:   cmd.op = OP_IT_J;
			ST_IT_K:   cmd.op = OP_IT_K;
			ST_IT_L:   cmd.op = OP_IT_L;
			ST_IT_M:   cmd.op = OP_IT_M;
			ST_IT_N:   cmd.op = OP_IT_N;
			ST_RC_A:   cmd.op = OP_RC_A;
			ST_RC_B:   cmd.op = OP_RC_B;
			ST_RC_C:   cmd.op = OP_RC_C;
			ST_DRE: begin
				cmd.op        = OP_NOP;
				cmd.div_start = 1'b1;
			end
			ST_WRE:    cmd.op = OP_NOP;
			ST_SRE:    cmd.op = OP_RC_SRE;
			ST_DIM: begin
				cmd.op        = OP_NOP;
				cmd.div_start = 1'b1;
				cmd.div_im    = 1'b1;
			end
			ST_WIM:    cmd.op = OP_NOP;
			ST_SIM:    cmd.op = OP_RC_SIM;
			ST_LV_A:   cmd.op = OP_LV_A;
			ST_LV_B:   cmd.op = OP_LV_B;
			ST_LV_C:   cmd.op = OP_LV_C;
			ST_LV_D:   cmd.op = OP_LV_D;
			ST_LV_E:   cmd.op = OP_LV_E;
			ST_LV_F:   cmd.op = OP_LV_F;
			ST_FIN:    cmd.op = OP_FIN;
			ST_COMMIT: cmd.op = OP_COMMIT;
			ST_OUT:    cmd.op = slot_free ? OP_OUT : OP_NOP;
			default:   cmd.op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
			rsel_q  <= 1'b0;
		end else begin
			if (state_q == ST_OUT && slot_free)
				valid_q <= 1'b1;
			else if (result_ready)
				valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE:   if (item_valid) state_q <= ST_SU_A;
				ST_SU_A:   state_q <= ST_SU_B;
				ST_SU_B:   state_q <= ST_SU_C;
				ST_SU_C:   state_q <= ST_SU_D;
				ST_SU_D:   state_q <= ST_SU_E;
				ST_SU_E:   state_q <= ST_IT_A;
				ST_IT_A:   state_q <= ST_IT_B;
				ST_IT_B:   state_q <= ST_IT_C;
				ST_IT_C:   state_q <= ST_IT_D;
				ST_IT_D: begin
					if (!stat.step && (stat.limit || stat.esc_hit))
						state_q <= ST_OUT;
					else
						state_q <= ST_IT_E;
				end
				ST_IT_E:   state_q <= ST_IT_F;
				ST_IT_F:   state_q <= ST_IT_G;
				ST_IT_G:   state_q <= ST_IT_H;
				ST_IT_H:   state_q <= ST_IT_I;
				ST_IT_I:   state_q <= ST_IT_J;
				ST_IT_J:   state_q <= ST_IT_K;
				ST_IT_K:   state_q <= ST_IT_L;
				ST_IT_L:   state_q <= ST_IT_M;
				ST_IT_M:   state_q <= ST_IT_N;
				ST_IT_N: begin
					rsel_q  <= 1'b0;
					state_q <= stat.cap ? ST_RC_A : ST_COMMIT;
				end
				ST_RC_A:   state_q <= ST_RC_B;
				ST_RC_B:   state_q <= ST_RC_C;
				ST_RC_C:   state_q <= ST_DRE;
				ST_DRE:    state_q <= ST_WRE;
				ST_WRE:    if (!stat.div_busy) state_q <= ST_SRE;
				ST_SRE:    state_q <= ST_DIM;
				ST_DIM:    state_q <= ST_WIM;
				ST_WIM:    if (!stat.div_busy) state_q <= ST_SIM;
				ST_SIM:    state_q <= rsel_q ? ST_FIN : ST_LV_A;
				ST_LV_A:   state_q <= ST_LV_B;
				ST_LV_B:   state_q <= ST_LV_C;
				ST_LV_C:   state_q <= ST_LV_D;
				ST_LV_D:   state_q <= ST_LV_E;
				ST_LV_E:   state_q <= ST_LV_F;
				ST_LV_F: begin
					rsel_q  <= 1'b1;
					state_q <= ST_RC_A;
				end
				ST_FIN:    state_q <= ST_COMMIT;
				ST_COMMIT: state_q <= stat.step ? ST_OUT : ST_IT_A;
				ST_OUT:    if (slot_free) state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

### sv/tricorn_lavaurs_escape_time.sv
// Sequence: the setup states, then per iteration the escape check and the update states,
// and the output state once the item ends; an iteration that enters the capture disc also
// forms two reciprocals around the Lavaurs step, each on the bit-serial divider.
// Throughput: one item at a time; the next beat is taken once the result is registered.
// Reset: arst_n clears the controller and loads the register defaults (p = 0.5,
// phase 0, eps about 0.005, limit 10000).
`default_nettype none

module tricorn_lavaurs_escape_time
	import tle_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              item_valid,
	output logic              item_ready,
	input  item_t             item,
	output logic              result_valid,
	input  logic              result_ready,
	output result_t           result
);

	cfg_t     cfg_q;
	cmd_t     cmd;
	stat_t    stat;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.p_re     <= P_RE_RST;
			cfg_q.p_im     <= P_IM_RST;
			cfg_q.phase    <= PHASE_RST;
			cfg_q.eps      <= EPS_RST;
			cfg_q.max_iter <= MAX_ITER_RST;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_P_RE:     cfg_q.p_re     <= pwdata;
				REG_P_IM:     cfg_q.p_im     <= pwdata;
				REG_PHASE:    cfg_q.phase    <= pwdata;
				REG_EPS:      cfg_q.eps      <= pwdata[30:0];
				REG_MAX_ITER: cfg_q.max_iter <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_P_RE:     prdata = cfg_q.p_re;
			REG_P_IM:     prdata = cfg_q.p_im;
			REG_PHASE:    prdata = cfg_q.phase;
			REG_EPS:      prdata = {1'b0, cfg_q.eps};
			REG_MAX_ITER: prdata = {16'd0, cfg_q.max_iter};
			default:      prdata = '0;
		endcase
	end

	tle_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.stat         (stat),
		.cmd          (cmd)
	);

	tle_dp #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.cfg    (cfg_q),
		.stat   (stat),
		.result (result)
	);

endmodule

`default_nettype wire

### sv/tle_checker.sv
// Port-level checks of the escape-time engine, bound to the top level.
// Depends on tle_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tle_checker
	import tle_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    pready,
	input logic    result_valid,
	input logic    result_ready,
	input result_t result
);

	`CHK_IMPL(a_pready_high, clk, arst_n, 1'b1, pready)
	`CHK_IMPL(a_count_even, clk, arst_n, result_valid, !result.count[0])
	`CHK_IMPL(a_no_esc_no_count, clk, arst_n, result_valid && !result.escaped, result.count == 17'd0)
	`CHK_NEXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(result))

endmodule

bind tricorn_lavaurs_escape_time tle_checker u_chk (.*);

`default_nettype wire

### sim/tb_top.sv
// Testbench for the tricorn escape-time engine with Lavaurs capture.
// Drives points over valid/ready and registers over APB, checks results against
// an internal fixed-point predictor; depends on tle_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
	import tle_pkg::*;

	localparam int FRAC = FRAC_BITS_DEF;
	localparam int IDLE_LIMIT = 200000;

	typedef struct {
		longint re;
		longint im;
	} cplx_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [CFG_AW-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        item_valid = 1'b0;
	logic        item_ready;
	item_t       item = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	result_t     result;

	longint  fp_re = P_RE_RST;
	longint  fp_im = P_IM_RST;
	longint  lv_phase = PHASE_RST;
	longint unsigned cap_eps = EPS_RST;
	longint unsigned iter_limit = MAX_ITER_RST;

	result_t pending_q[$];
	int      send_idle = 0;
	int      recv_idle = 0;
	int      hold_req = 0;
	int      hold_left = 0;
	int      idle_cycles = 0;
	int      n_items = 0;
	int      n_results = 0;
	int      n_escaped = 0;
	int      n_cfg = 0;
	bit      failed = 1'b0;

	tricorn_lavaurs_escape_time uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result)
	);

	always #6 clk = ~clk;

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint fxmul(longint a, longint b);
		longint prod;
		prod = a * b;
		return prod >>> FRAC;
	endfunction

	function automatic longint unsigned sq(longint v);
		return longint'(v * v);
	endfunction

	function automatic longint unsigned mag(longint v);
		return (v < 0) ? longint'(-v) : longint'(v);
	endfunction

	function automatic cplx_t cmul(cplx_t a, cplx_t b);
		cplx_t r;
		r.re = sat32(fxmul(a.re, b.re) - fxmul(a.im, b.im));
		r.im = sat32(fxmul(a.re, b.im) + fxmul(a.im, b.re));
		return r;
	endfunction

	function automatic longint unsigned scaled_quot(longint unsigned a, longint unsigned den);
		longint unsigned r, q, b;
		r = 0;
		q = 0;
		for (int k = 31 + 2 * FRAC; k >= 0; k--) begin
			b = (k >= 2 * FRAC) ? ((a >> (k - 2 * FRAC)) & 1) : 0;
			r = (r << 1) | b;
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q = q | 1;
			end
			if (q > 64'h8000_0000) q = 64'h8000_0000;
		end
		return q;
	endfunction

	function automatic cplx_t neg_inverse(cplx_t d);
		cplx_t r;
		longint unsigned n, q;
		n = sq(d.re) + sq(d.im);
		r.re = 0;
		r.im = 0;
		if (n == 0) return r;
		q = scaled_quot(mag(d.re), n);
		r.re = sat32(d.re > 0 ? -longint'(q) : longint'(q));
		q = scaled_quot(mag(d.im), n);
		r.im = sat32(d.im < 0 ? -longint'(q) : longint'(q));
		return r;
	endfunction

	function automatic cplx_t tricorn_step(cplx_t z, cplx_t c, cplx_t a2);
		cplx_t n, e, d, w;
		longint vr, adj;
		longint unsigned ip;
		n.re = sat32(fxmul(z.re, z.re) - fxmul(z.im, z.im) + c.re);
		n.im = sat32(-2 * fxmul(z.re, z.im) + c.im);
		e.re = sat32(n.re - fp_re);
		e.im = sat32(n.im - fp_im);
		d = cmul(a2, e);
		vr = sat32(d.re + longint'(cap_eps));
		if (sq(vr) + sq(d.im) < cap_eps * cap_eps) begin
			w = neg_inverse(d);
			ip = (mag(w.re) >> FRAC) << FRAC;
			adj = longint'(2 * ip);
			w.re = sat32(w.re - (w.re < 0 ? -adj : adj) + lv_phase);
			w = neg_inverse(cmul(a2, w));
			n.re = sat32(w.re + fp_re);
			n.im = sat32(w.im + fp_im);
		end
		return n;
	endfunction

	function automatic result_t predict_escape(item_t it);
		result_t r;
		cplx_t z, c, a2;
		longint sq_re, sq_im;
		longint unsigned i;
		z.re = it.z_re;
		z.im = it.z_im;
		sq_re = fxmul(fp_re, fp_re) - fxmul(fp_im, fp_im);
		sq_im = 2 * fxmul(fp_re, fp_im);
		c.re = sat32(fp_re - sq_re);
		c.im = sat32(fp_im + sq_im);
		a2.re = sat32(4 * sq_re + 2 * fp_re);
		a2.im = sat32(4 * sq_im - 2 * fp_im);
		r = '0;
		if (it.action) begin
			z = tricorn_step(z, c, a2);
		end else begin
			i = 0;
			while (i < iter_limit &&
					((sq(z.re) + sq(z.im)) >> FRAC) < (64'd10 << FRAC)) begin
				z = tricorn_step(z, c, a2);
				i++;
			end
			if (i < iter_limit) begin
				r.escaped = 1'b1;
				r.count = 17'(2 * i);
			end
		end
		r.z_re_out = z.re[31:0];
		r.z_im_out = z.im[31:0];
		return r;
	endfunction

	// receiver: random stalls plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && result_valid && result_ready) begin
			n_results++;
			if (pending_q.size() == 0) begin
				$error("result beat with no expectation pending");
				failed = 1'b1;
			end else begin
				exp_r = pending_q.pop_front();
				if (result.escaped) n_escaped++;
				if (result.escaped !== exp_r.escaped) begin
					$error("escaped exp %0d got %0d", exp_r.escaped, result.escaped);
					failed = 1'b1;
				end
				if (result.count !== exp_r.count) begin
					$error("count exp %0d got %0d", exp_r.count, result.count);
					failed = 1'b1;
				end
				if (result.z_re_out !== exp_r.z_re_out) begin
					$error("z_re_out exp %0d got %0d", exp_r.z_re_out, result.z_re_out);
					failed = 1'b1;
				end
				if (result.z_im_out !== exp_r.z_im_out) begin
					$error("z_im_out exp %0d got %0d", exp_r.z_im_out, result.z_im_out);
					failed = 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready) || psel)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// must be followed by send_point or drop_valid without time advancing
	task automatic send_point(bit act, longint zr, longint zi);
		item_t it;
		it.action = act;
		it.z_re = zr[31:0];
		it.z_im = zi[31:0];
		while ($urandom_range(99) < send_idle) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (!item_ready);
		pending_q.push_back(predict_escape(it));
		n_items++;
	endtask

	task automatic drop_valid();
		item_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic cfg_write(reg_idx_t idx, logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CFG_AW'(4 * idx);
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		n_cfg++;
		case (idx)
			REG_P_RE: fp_re = longint'(signed'(v));
			REG_P_IM: fp_im = longint'(signed'(v));
			REG_PHASE: lv_phase = longint'(signed'(v));
			REG_EPS: cap_eps = v[30:0];
			REG_MAX_ITER: iter_limit = v[15:0];
			default: ;
		endcase
	endtask

	task automatic set_all(logic [31:0] pr, logic [31:0] pi, logic [31:0] ph,
			logic [31:0] ep, logic [31:0] mi);
		wait_drained();
		cfg_write(REG_P_RE, pr);
		cfg_write(REG_P_IM, pi);
		cfg_write(REG_PHASE, ph);
		cfg_write(REG_EPS, ep);
		cfg_write(REG_MAX_ITER, mi);
	endtask

	task automatic test_reset_defaults();
		send_point(0, 64'sd2 <<< FRAC, 0);
		send_point(0, 0, 64'sd3 <<< FRAC);
		send_point(0, 64'sd2147483647, -64'sd2147483648);
		send_point(1, 64'sd8346665, 0);
		send_point(1, 0, 0);
		send_point(1, -64'sd2147483648, 64'sd2147483647);
		drop_valid();
	endtask

	task automatic test_limits();
		set_all(32'd8388608, 0, 0, 32'd83886, 32'd0);
		send_point(0, 64'sd5 <<< FRAC, 0);
		drop_valid();
		wait_drained();
		cfg_write(REG_MAX_ITER, 32'd1);
		send_point(0, 64'sd2 <<< FRAC, 0);
		send_point(0, 64'sd8346665, 0);
		drop_valid();
		wait_drained();
		cfg_write(REG_MAX_ITER, 32'd2);
		send_point(0, 64'sd2 <<< FRAC, 0);
		drop_valid();
		wait_drained();
		cfg_write(REG_MAX_ITER, 32'hFFFF);
		send_point(0, 64'sd2 <<< FRAC, 64'sd1 <<< FRAC);
		send_point(0, -64'sd2147483648, -64'sd2147483648);
		drop_valid();
	endtask

	task automatic test_capture();
		set_all(32'd8388608, 0, 32'h7FFF_FFFF, 32'd83886, 32'd12);
		send_point(1, 64'sd8346665, 0);
		send_point(0, 64'sd8346665, 64'sd100);
		drop_valid();
		set_all(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd6);
		send_point(1, 64'sd1 <<< FRAC, 0);
		send_point(0, 0, 0);
		drop_valid();
		set_all(32'hF800_0000, 0, 32'd0, 32'd0, 32'd8);
		send_point(0, 0, 0);
		send_point(1, 64'sd4194304, 64'sd1000);
		drop_valid();
		set_all(32'h7FFF_FFFF, 32'h8000_0000, 32'd5 << FRAC, 32'h4000_0000, 32'd4);
		send_point(1, 64'sd1234567, -64'sd7654321);
		send_point(0, -64'sd1, 64'sd1);
		drop_valid();
	endtask

	task automatic test_random(int n);
		longint zr, zi;
		for (int k = 0; k < n; k++) begin
			if (k % 12 == 0) begin
				drop_valid();
				set_all($urandom_range(1) ? $urandom : 32'($signed($urandom_range(33554432)) - 16777216),
					32'($signed($urandom_range(33554432)) - 16777216),
					$urandom,
					$urandom_range(3) == 0 ? $urandom : $urandom_range(4000000),
					$urandom_range(24, 1));
			end
			case ($urandom_range(3))
				0: begin
					zr = longint'(signed'($urandom));
					zi = longint'(signed'($urandom));
				end
				default: begin
					zr = sat32(fp_re + longint'($urandom_range(2 * cap_eps + 2)) - longint'(cap_eps));
					zi = sat32(fp_im + longint'($urandom_range(2 * cap_eps + 2)) - longint'(cap_eps));
				end
			endcase
			send_point($urandom_range(1), zr, zi);
		end
		drop_valid();
	endtask

	task automatic test_backpressure();
		set_all(32'd8388608, 32'd1000000, 32'd3 << FRAC, 32'd500000, 32'd5);
		send_idle = 0;
		hold_req = 600;
		for (int k = 0; k < 6; k++)
			send_point($urandom_range(1), longint'(signed'($urandom)) >>> 4, 64'sd20000);
		drop_valid();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_limits();
		test_capture();
		send_idle = 21;
		recv_idle = 61;
		test_random(28);
		send_idle = 61;
		recv_idle = 21;
		test_random(28);
		send_idle = 0;
		recv_idle = 0;
		test_random(28);
		test_backpressure();
		wait_drained();
		repeat (200) @(posedge clk);
		$display("Covered %0d points (%0d escaped) over %0d register writes,",
			n_items, n_escaped, n_cfg);
		$display("with limit, capture, saturation and stall cases; %0d results.", n_results);
		if (!failed && pending_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
